@@ hdl/integer_stack_alu_top_assert.svh @@
// Assertion macros for the stack ALU.
`ifndef INTEGER_STACK_ALU_TOP_ASSERT_SVH
`define INTEGER_STACK_ALU_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define ISA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ISA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/isa_pkg.sv @@
package isa_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W = 5;
  localparam int DEPTH_DEF = 16;
  localparam int CAP_RST = 16;

  localparam logic [2:0] K_PUSH = 3'd0;
  localparam logic [2:0] K_POP  = 3'd1;
  localparam logic [2:0] K_ADD  = 3'd2;
  localparam logic [2:0] K_SUB  = 3'd3;
  localparam logic [2:0] K_MUL  = 3'd4;
  localparam logic [2:0] K_DIV  = 3'd5;
  localparam logic [2:0] K_SUM  = 3'd6;
  localparam logic [2:0] K_PROD = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // Per-cycle shift command to the cell chain.
  typedef struct packed {
    logic up;      // every cell takes its lower neighbor's word (push)
    logic down;    // every cell takes its upper neighbor's word (pop)
  } chain_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DROP, S_DIV, S_SIGN, S_RED, S_WB, S_DONE
  } fsm_t;

endpackage

@@ hdl/isa_cell.sv @@
// One stack cell: holds a word, shifts with its neighbors.
module isa_cell (
  input  logic                      clk,
  input  isa_pkg::chain_ctl_t       ctl,
  input  logic [isa_pkg::DATA_W-1:0] below_i,
  input  logic [isa_pkg::DATA_W-1:0] above_i,
  output logic [isa_pkg::DATA_W-1:0] word_o
);
  import isa_pkg::*;

  logic [DATA_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (ctl.up) begin
      word_r <= below_i;
    end else if (ctl.down) begin
      word_r <= above_i;
    end
  end

  assign word_o = word_r;
endmodule

@@ hdl/isa_chain.sv @@
// Row of cells; cell 0 is the top of stack. Rotation (down with wrap)
// walks the entries past cell 0 for reductions.
module isa_chain #(
  parameter int DEPTH = isa_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  isa_pkg::chain_ctl_t        ctl,
  input  logic [isa_pkg::DATA_W-1:0] load_i,
  input  logic [isa_pkg::DATA_W-1:0] tail_i,
  output logic [isa_pkg::DATA_W-1:0] top_o,
  output logic [isa_pkg::DATA_W-1:0] next_o
);
  import isa_pkg::*;

  logic [DATA_W-1:0] w [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] bl, ab;
    if (g == 0) begin : g_t
      assign bl = load_i;
    end else begin : g_m
      assign bl = w[g-1];
    end
    if (g == DEPTH-1) begin : g_b
      assign ab = tail_i;
    end else begin : g_n
      assign ab = w[g+1];
    end
    isa_cell u_cell (.clk(clk), .ctl(ctl), .below_i(bl), .above_i(ab), .word_o(w[g]));
  end

  assign top_o  = w[0];
  assign next_o = w[1];
endmodule

@@ hdl/integer_stack_alu_top.sv @@
// Stack ALU, one request at a time: EXEC, then DONE with out_valid. Push, pop,
// overflow and underflow go straight to DONE; divide by zero via DROP; add,
// sub, mul via DROP, WB; divide via DROP, DIV (one quotient bit a cycle), SIGN,
// WB; sum/product all via RED, WB (empty sum: WB only). The receiver cannot
// stall. busy holds through out_valid; a new start is taken once it falls.
// Synchronous active-low reset empties the stack, capacity 16; words kept.
module integer_stack_alu_top #(
  parameter int DEPTH = isa_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_kind,
  input  logic signed [isa_pkg::DATA_W-1:0] in_operand,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic signed [isa_pkg::DATA_W-1:0] out_value,
  output logic [isa_pkg::CNT_W-1:0]   out_depth,
  input  logic                        cfg_we,
  input  logic [isa_pkg::CNT_W-1:0]   cfg_data
);
  import isa_pkg::*;
  `include "integer_stack_alu_top_assert.svh"

  localparam int CW = $clog2(DEPTH + 1);

  // Control and bookkeeping
  fsm_t              state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic [2:0]        kind_r;
  logic [DATA_W-1:0] opnd_r;
  logic [CW-1:0]     rot_r;        // reduction steps remaining
  logic [4:0]        dcnt_r;       // divide step counter
  logic [DATA_W-1:0] acc_r;        // result word / reduction accumulator
  logic [DATA_W-1:0] dq_r, drem_r, dden_r;
  logic              dneg_r;
  logic [1:0]        st_r, st_nxt;
  logic [DATA_W-1:0] top_w, next_w;
  chain_ctl_t        ctl;
  logic [DATA_W-1:0] load_w;
  logic [CW-1:0]     lim_w;
  logic              bin_op, red_op;

  // Effective capacity clamped to 1..DEPTH
  always_comb begin
    if (cap_r == '0) lim_w = CW'(1);
    else if (32'(cap_r) > DEPTH) lim_w = CW'(DEPTH);
    else lim_w = CW'(cap_r);
  end

  // Cell 0 is the top of stack; down wraps cell 0 into the last cell.
  isa_chain #(.DEPTH(DEPTH)) u_chain (
    .clk(clk), .ctl(ctl), .load_i(load_w), .tail_i(top_w),
    .top_o(top_w), .next_o(next_w)
  );

  assign bin_op = kind_r inside {K_ADD, K_SUB, K_MUL, K_DIV};
  assign red_op = kind_r inside {K_SUM, K_PROD};

  // Status of the request, decided in its first cycle
  always_comb begin
    st_nxt = ST_OK;
    case (kind_r)
      K_PUSH: if (cnt_r >= lim_w) st_nxt = ST_OVER;
      K_POP, K_PROD: if (cnt_r == '0) st_nxt = ST_UNDER;
      K_SUM: st_nxt = ST_OK;
      default: begin
        if (cnt_r < CW'(2)) st_nxt = ST_UNDER;
        else if (kind_r == K_DIV && top_w == '0) st_nxt = ST_DIVZ;
      end
    endcase
  end

  // Next-state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: begin
        if (st_nxt == ST_OVER || st_nxt == ST_UNDER) state_nxt = S_DONE;
        else if (kind_r inside {K_PUSH, K_POP}) state_nxt = S_DONE;
        else if (bin_op) state_nxt = S_DROP;
        else if (cnt_r == '0) state_nxt = S_WB;      // empty sum pushes zero
        else state_nxt = S_RED;
      end
      S_DROP: begin
        if (st_r != ST_OK) state_nxt = S_DONE;        // divide by zero
        else if (kind_r == K_DIV) state_nxt = S_DIV;
        else state_nxt = S_WB;
      end
      S_DIV:  if (dcnt_r == 5'(DATA_W - 1)) state_nxt = S_SIGN;
      S_SIGN: state_nxt = S_WB;
      S_RED:  if (rot_r <= CW'(1)) state_nxt = S_WB;
      S_WB:   state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Chain control. Binary ops drop both operands (EXEC, DROP) and push the
  // result in WB. Reductions rotate the entries past cell 0 one a cycle,
  // then push the result; words left below it are dead.
  always_comb begin
    ctl = '0;
    load_w = acc_r;
    case (state_r)
      S_EXEC: begin
        if (kind_r == K_PUSH) begin
          ctl.up = (st_nxt == ST_OK);
          load_w = opnd_r;
        end else if (!red_op) begin
          ctl.down = (st_nxt == ST_OK) || (st_nxt == ST_DIVZ);
        end
      end
      S_DROP: ctl.down = 1'b1;
      S_RED:  ctl.down = 1'b1;
      S_WB:   ctl.up = 1'b1;
      default: ;
    endcase
  end

  // Shared multiplier: top*next for multiply, acc*top for product all
  logic [DATA_W-1:0] mul_a, mul_w;
  assign mul_a = (state_r == S_RED) ? acc_r : next_w;
  assign mul_w = mul_a * top_w;

  // Divider helpers (restoring, on magnitudes)
  logic [DATA_W:0]   dtrial;
  logic [DATA_W-1:0] rshift;
  assign rshift = {drem_r[DATA_W-2:0], dq_r[DATA_W-1]};
  assign dtrial = {1'b0, rshift} - {1'b0, dden_r};

  logic [DATA_W-1:0] abs_top, abs_next;
  assign abs_top  = top_w[DATA_W-1] ? -top_w : top_w;
  assign abs_next = next_w[DATA_W-1] ? -next_w : next_w;

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (start) begin
        kind_r <= in_kind;
        opnd_r <= in_operand;
      end
      S_EXEC: begin
        case (kind_r)
          K_PUSH:  acc_r <= opnd_r;
          K_POP:   acc_r <= top_w;
          K_ADD:   acc_r <= top_w + next_w;
          K_SUB:   acc_r <= top_w - next_w;
          K_MUL:   acc_r <= mul_w;
          K_SUM:   acc_r <= '0;
          K_PROD:  acc_r <= DATA_W'(1);
          default: acc_r <= '0;          // divide: quotient set in S_SIGN
        endcase
        rot_r <= cnt_r;
        dq_r <= abs_next;
        drem_r <= '0;
        dden_r <= abs_top;
        dneg_r <= top_w[DATA_W-1] ^ next_w[DATA_W-1];
        dcnt_r <= '0;
      end
      S_DIV: begin
        dcnt_r <= dcnt_r + 5'd1;
        if (!dtrial[DATA_W]) begin
          drem_r <= dtrial[DATA_W-1:0];
          dq_r <= {dq_r[DATA_W-2:0], 1'b1};
        end else begin
          drem_r <= rshift;
          dq_r <= {dq_r[DATA_W-2:0], 1'b0};
        end
      end
      S_SIGN: acc_r <= dneg_r ? -dq_r : dq_r;
      S_RED: begin
        rot_r <= rot_r - CW'(1);
        if (kind_r == K_SUM) acc_r <= acc_r + top_w;
        else acc_r <= mul_w;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      cap_r <= CNT_W'(CAP_RST);
      st_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) cap_r <= cfg_data;
      if (state_r == S_EXEC) st_r <= st_nxt;
    end
  end

  // Entry count follows the chain moves
  always_comb begin
    cnt_nxt = cnt_r;
    case (state_r)
      S_EXEC: begin
        if (kind_r == K_PUSH && st_nxt == ST_OK) cnt_nxt = cnt_r + CW'(1);
        else if (kind_r == K_POP && st_nxt == ST_OK) cnt_nxt = cnt_r - CW'(1);
        else if (bin_op && st_nxt != ST_UNDER) cnt_nxt = cnt_r - CW'(2);
      end
      S_WB: cnt_nxt = red_op ? CW'(1) : cnt_r + CW'(1);
      default: ;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_DONE);
  assign out_status = st_r;
  assign out_value  = (st_r == ST_OK) ? acc_r : '0;
  assign out_depth  = CNT_W'(cnt_r);

  `ISA_ASSERT_IMP(a_busy_done, out_valid, busy)
  `ISA_ASSERT_NXT(a_done_idle, out_valid, !busy)
  `ISA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH))
  `ISA_ASSERT_IMP(a_err_zero, out_valid && st_r != ST_OK, out_value == '0)
endmodule
